FILE: rtl/pea_pkg.sv
`default_nettype none

package pea_pkg;

   localparam int VEC_W      = 6;
   localparam int PRIO_W     = 3;
   localparam int PREEMPT_W  = 5;
   localparam int KEY_W      = VEC_W + 1;
   localparam int MASK_W     = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register indexes, taken from paddr[2].
   localparam logic CSR_PREEMPT_MASK  = 1'b0;
   localparam logic CSR_PRIORITY_MASK = 1'b1;

   localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic raise_commit;
      logic empty_finish;
      logic scan_step;
      logic decide_commit;
   } pea_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_check;
      logic count_zero;
      logic scan_last;
   } pea_status_type;

   // Fixed priority of a vector: the three system vectors are negative.
   function automatic logic signed [PRIO_W-1:0] prio_of(input logic [VEC_W-1:0] v);
      logic signed [PRIO_W-1:0] p;
      case (v)
         6'd1:    p = -3'sd3;
         6'd2:    p = -3'sd2;
         6'd3:    p = -3'sd1;
         default: p = 3'sd0;
      endcase
      return p;
   endfunction

   // Ordering key: the system vectors sort first, then every other vector by number.
   function automatic logic [KEY_W-1:0] key_of(input logic [VEC_W-1:0] v);
      return {(prio_of(v) == 3'sd0), v};
   endfunction

   // Negative priorities stay unmasked; others go through both masks.
   function automatic logic signed [PREEMPT_W-1:0] preempt_of(
      input logic signed [PRIO_W-1:0] p,
      input logic [MASK_W-1:0]        impl_mask,
      input logic [MASK_W-1:0]        sel_mask);
      logic signed [PREEMPT_W-1:0] r;
      if (p < 0) begin
         r = PREEMPT_W'(p);
      end else begin
         r = $signed({1'b0, ({1'b0, p} & impl_mask & sel_mask)});
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pea_csr.sv
`default_nettype none

module pea_csr
   import pea_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [MASK_W-1:0]     preempt_sel_mask,
   output logic      [MASK_W-1:0]     priority_mask
);

   logic [MASK_W-1:0] preempt_sel_ff, preempt_sel_in;
   logic [MASK_W-1:0] priority_mask_ff, priority_mask_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      preempt_sel_in   = preempt_sel_ff;
      priority_mask_in = priority_mask_ff;
      if (wr_en) begin
         unique case (paddr[2])
            CSR_PREEMPT_MASK:  preempt_sel_in   = pwdata[MASK_W-1:0];
            CSR_PRIORITY_MASK: priority_mask_in = pwdata[MASK_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_PREEMPT_MASK:  prdata = {{(CSR_DATA_W-MASK_W){1'b0}}, preempt_sel_ff};
         CSR_PRIORITY_MASK: prdata = {{(CSR_DATA_W-MASK_W){1'b0}}, priority_mask_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preempt_sel_ff   <= MASK_RESET;
         priority_mask_ff <= MASK_RESET;
      end else begin
         preempt_sel_ff   <= preempt_sel_in;
         priority_mask_ff <= priority_mask_in;
      end
   end

   assign preempt_sel_mask = preempt_sel_ff;
   assign priority_mask    = priority_mask_ff;

endmodule

`default_nettype wire

FILE: rtl/pea_ctrl.sv
`default_nettype none

module pea_ctrl
   import pea_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   input  wire pea_status_type status,
   output pea_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DISPATCH = 5'b00010,
      ST_SCAN     = 5'b00100,
      ST_DRAIN    = 5'b01000,
      ST_DECIDE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!status.req_is_check) begin
               cmd.raise_commit = 1'b1;
               state_in         = ST_IDLE;
            end else if (status.count_zero) begin
               cmd.empty_finish = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide_commit = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/pea_dp.sv
`default_nettype none

module pea_dp
   import pea_pkg::*;
#(
   parameter int NUM_VECTORS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pea_cmd_type        cmd,
   output pea_status_type          status,
   input  wire logic               req_op,
   input  wire logic [VEC_W-1:0]   req_vector,
   input  wire logic               req_in_handler,
   input  wire logic [VEC_W-1:0]   req_current_vector,
   input  wire logic [MASK_W-1:0]  preempt_sel_mask,
   input  wire logic [MASK_W-1:0]  priority_mask,
   output logic                    rsp_valid,
   output logic                    rsp_accepted,
   output logic      [VEC_W-1:0]   rsp_taken_vector
);

   localparam int IDX_W = $clog2(NUM_VECTORS);
   localparam int CNT_W = $clog2(NUM_VECTORS + 1);

   logic [VEC_W-1:0] mem [NUM_VECTORS];

   logic             op_ff, handler_ff;
   logic [VEC_W-1:0] vec_ff, cur_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic [VEC_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_valid_ff;
   logic [VEC_W-1:0] best_ff, last_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_accepted_ff, rsp_accepted_in;
   logic [VEC_W-1:0] rsp_taken_ff, rsp_taken_in;

   logic                        raise_ok;
   logic                        take;
   logic                        mem_we;
   logic [IDX_W-1:0]            mem_waddr;
   logic [VEC_W-1:0]            mem_wdata;
   logic                        better;
   logic signed [PRIO_W-1:0]    cur_prio;
   logic signed [PREEMPT_W-1:0] top_preempt, cur_preempt;

   assign status.req_is_check = op_ff;
   assign status.count_zero   = (count_ff == '0);
   assign status.scan_last    = ({{(CNT_W-IDX_W){1'b0}}, scan_idx_ff} == count_ff - CNT_W'(1));

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff      <= req_op;
         vec_ff     <= req_vector;
         handler_ff <= req_in_handler;
         cur_ff     <= req_current_vector;
      end
   end

   assign raise_ok = (32'(vec_ff) < NUM_VECTORS) && (count_ff < CNT_W'(NUM_VECTORS));

   // Preemption test of the smallest entry against the vector being handled.
   assign cur_prio    = (32'(cur_ff) < NUM_VECTORS) ? prio_of(cur_ff) : 3'sd0;
   assign top_preempt = preempt_of(prio_of(best_ff), priority_mask, preempt_sel_mask);
   assign cur_preempt = preempt_of(cur_prio, priority_mask, preempt_sel_mask);
   assign take        = !handler_ff || (top_preempt < cur_preempt);

   assign better = (rd_idx_ff == '0) || (key_of(rd_data_ff) < key_of(best_ff));

   // A pop moves the last entry into the hole left by the popped one.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = count_ff[IDX_W-1:0];
      mem_wdata = vec_ff;
      if (cmd.raise_commit && raise_ok) begin
         mem_we = 1'b1;
      end
      if (cmd.decide_commit && take) begin
         mem_we    = 1'b1;
         mem_waddr = best_idx_ff;
         mem_wdata = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_idx_ff];
   end

   always_comb begin
      count_in        = count_ff;
      scan_idx_in     = scan_idx_ff;
      rsp_valid_in    = 1'b0;
      rsp_accepted_in = 1'b0;
      rsp_taken_in    = '0;
      if (cmd.load_req) begin
         scan_idx_in = '0;
      end
      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
      if (cmd.raise_commit) begin
         rsp_valid_in    = 1'b1;
         rsp_accepted_in = raise_ok;
         if (raise_ok) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.empty_finish) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.decide_commit) begin
         rsp_valid_in = 1'b1;
         if (take) begin
            count_in     = count_ff - CNT_W'(1);
            rsp_taken_in = best_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         rd_valid_ff  <= cmd.scan_step;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff       <= scan_idx_ff;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_taken_ff    <= rsp_taken_in;
      if (rd_valid_ff) begin
         last_ff <= rd_data_ff;
         if (better) begin
            best_ff     <= rd_data_ff;
            best_idx_ff <= rd_idx_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_taken_vector = rsp_taken_ff;

endmodule

`default_nettype wire

FILE: rtl/pending_exception_arbiter.sv
// Pending-exception queue of an interrupt controller. A request with req_op low raises
// req_vector into the pending store; a request with req_op high checks for an exception
// to take and, in thread mode or when the smallest pending entry preempts
// req_current_vector in handler mode, pops it. Every request gives exactly one result,
// strobed by rsp_valid for a single cycle; the receiver cannot stall it, so it must
// capture rsp_accepted and rsp_taken_vector in that cycle. A request is taken when start
// is high and busy is low. A raise or a check on an empty store is settled in the dispatch
// state and its result is registered. A check with entries pending goes on through the
// scan, drain and decide states first, because the store sits in a memory with one read
// port that is scanned one entry per cycle to find the most urgent entry. busy falls in
// the cycle in which the result is strobed, so a new request may be given then.
`default_nettype none

module pending_exception_arbiter
   import pea_pkg::*;
#(
   parameter int NUM_VECTORS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_op,
   input  wire logic [VEC_W-1:0]      req_vector,
   input  wire logic                  req_in_handler,
   input  wire logic [VEC_W-1:0]      req_current_vector,
   output logic                       rsp_valid,
   output logic                       rsp_accepted,
   output logic      [VEC_W-1:0]      rsp_taken_vector,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   pea_cmd_type       cmd;
   pea_status_type    status;
   logic [MASK_W-1:0] preempt_sel_mask;
   logic [MASK_W-1:0] priority_mask;

   // The controller sequences each request: dispatch, then for a check on a non-empty store a
   // scan of the store, a drain state for the last memory read and a decision.
   pea_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath holds the pending store, its fill count, the running minimum
   // of the scan and the registered result.
   pea_dp #(
      .NUM_VECTORS (NUM_VECTORS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_vector         (req_vector),
      .req_in_handler     (req_in_handler),
      .req_current_vector (req_current_vector),
      .preempt_sel_mask   (preempt_sel_mask),
      .priority_mask      (priority_mask),
      .rsp_valid          (rsp_valid),
      .rsp_accepted       (rsp_accepted),
      .rsp_taken_vector   (rsp_taken_vector)
   );

   // The two mask registers sit behind the configuration port.
   pea_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .preempt_sel_mask (preempt_sel_mask),
      .priority_mask    (priority_mask)
   );

endmodule

`default_nettype wire

FILE: rtl/pea_checker.sv
`default_nettype none

module pea_checker
   import pea_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire logic             rsp_accepted,
   input wire logic [VEC_W-1:0] rsp_taken_vector
);

   // An accepted request keeps the block busy until its result.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not make the block busy");

   // The result is strobed in the cycle the block becomes free again.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy fell without a result");

   // No result while a request is still being worked on.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while busy");

   // A stored raise never reports a taken vector.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_taken_vector == '0)
      else $error("raise result carries a taken vector");

endmodule

bind pending_exception_arbiter pea_checker u_pea_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_accepted     (rsp_accepted),
   .rsp_taken_vector (rsp_taken_vector)
);

`default_nettype wire
